[rtl/siq_pkg.sv]
// ============================================================================
// siq_pkg
// Shared types and constants for the sorted insert queue: item payloads,
// operation and status codes, sequencer states and the entry store controls.
// ============================================================================
package siq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 32;
    localparam int TAG_W         = 16;
    localparam int COUNT_OUT_W   = 5;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_POP    = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        func_t              func;
        logic [KEY_W-1:0]   sort_key;
        logic [TAG_W-1:0]   record_tag;
    } in_t;

    typedef struct packed {
        status_t                status;
        logic                   head_valid;
        logic [KEY_W-1:0]       head_key;
        logic [TAG_W-1:0]       head_tag;
        logic [KEY_W-1:0]       tail_key;
        logic [TAG_W-1:0]       tail_tag;
        logic [COUNT_OUT_W-1:0] entry_count;
    } out_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic pop;
        logic clear;
    } store_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_PUT,
        ST_HEAD_RD,
        ST_HEAD_CAP,
        ST_EMIT
    } state_t;

endpackage

[rtl/siq_store.sv]
// ============================================================================
// siq_store
// Entry RAM kept as a circular buffer. A single address unit maps a logical
// position onto a RAM address relative to the head pointer; pop advances the
// head pointer through the same unit.
// ============================================================================
module siq_store #(
    parameter int DEPTH = siq_pkg::DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  siq_pkg::store_ctl_t          ctl,
    input  logic [$clog2(DEPTH+1)-1:0]   idx,
    input  siq_pkg::entry_t              wr_entry,
    output siq_pkg::entry_t              rd_entry
);
    import siq_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    entry_t             mem [DEPTH];
    entry_t             rd_entry_reg;
    logic [PTR_W-1:0]   base_reg;
    logic [PTR_W-1:0]   base_next;
    logic [SUM_W-1:0]   addr_sum;
    logic [SUM_W-1:0]   addr_wrap;
    logic [PTR_W-1:0]   addr;

    // logical position to ram address
    assign addr_sum  = SUM_W'(base_reg) + SUM_W'(idx);
    assign addr_wrap = (addr_sum >= SUM_W'(DEPTH)) ? addr_sum - SUM_W'(DEPTH) : addr_sum;
    assign addr      = addr_wrap[PTR_W-1:0];

    always_comb
    begin
        base_next = base_reg;
        if (ctl.clear)
        begin
            base_next = '0;
        end
        else if (ctl.pop)
        begin
            base_next = addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wr_entry;
        end
        if (ctl.rd_en)
        begin
            rd_entry_reg <= mem[addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

[rtl/sorted_insert_queue.sv]
// ============================================================================
// sorted_insert_queue
// Bounded queue of (key, tag) entries with sorted insert, append, pop and
// clear; one result item per input item.
// ============================================================================
// One item is worked at a time; in_ready is high only while the sequencer is
// idle. All entry traffic goes through one single-port entry RAM with a
// registered read, so read data can be used only in the cycle after the read.
// A sorted insert scans the held entries one at a time from the head until
// the insertion point, then shifts entries one place at a time from the tail
// down to it. A waiting result does not hold off the next item; only the
// final load into the output register waits.
module sorted_insert_queue #(
    parameter int DEPTH = siq_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  siq_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output siq_pkg::out_t   out_data
);
    import siq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   pos_next;
    entry_t             op_reg;
    entry_t             op_next;
    status_t            status_reg;
    status_t            status_next;
    entry_t             head_reg;
    entry_t             head_next;
    out_t               out_reg;
    out_t               out_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    store_ctl_t         ctl;
    logic [CNT_W-1:0]   mem_idx;
    entry_t             wr_entry;
    entry_t             rd_entry;

    logic [CNT_W-1:0]   idx_dec;
    logic [CNT_W-1:0]   idx_inc;
    logic [CNT_W-1:0]   count_dec;
    logic               full;
    logic               empty;
    logic               hit;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign idx_dec   = idx_reg - CNT_W'(1);
    assign idx_inc   = idx_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign count_ext = (CNT_W+COUNT_OUT_W)'(count_reg);

    // scan compare: strictly greater at the head, greater or equal after it
    assign hit = (rd_entry.key < op_reg.key)
              || ((rd_entry.key == op_reg.key) && (idx_reg != '0));

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        head_next      = head_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        ctl            = '0;
        mem_idx        = idx_reg;
        wr_entry       = rd_entry;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next.key = in_data.sort_key;
                    op_next.tag = in_data.record_tag;
                    status_next = STAT_OK;
                    unique case (in_data.func)
                        FUNC_INSERT, FUNC_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                                state_next  = ST_HEAD_RD;
                            end
                            else if (in_data.func == FUNC_APPEND || empty)
                            begin
                                pos_next   = count_reg;
                                state_next = ST_PUT;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        FUNC_POP:
                        begin
                            if (empty)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = ST_HEAD_RD;
                            end
                            else
                            begin
                                state_next = ST_POP;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            ctl.clear  = 1'b1;
                            count_next = '0;
                            state_next = ST_HEAD_RD;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                ctl.pop    = 1'b1;
                mem_idx    = CNT_W'(1);
                count_next = count_dec;
                state_next = ST_HEAD_RD;
            end
            ST_SCAN_RD:
            begin
                ctl.rd_en  = 1'b1;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                if (hit)
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = ST_SH_RD;
                end
                else if (idx_inc == count_reg)
                begin
                    pos_next   = count_reg;
                    state_next = ST_PUT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SH_RD:
            begin
                ctl.rd_en  = 1'b1;
                mem_idx    = idx_dec;
                state_next = ST_SH_WR;
            end
            ST_SH_WR:
            begin
                ctl.wr_en  = 1'b1;
                idx_next   = idx_dec;
                state_next = (idx_dec == pos_reg) ? ST_PUT : ST_SH_RD;
            end
            ST_PUT:
            begin
                ctl.wr_en  = 1'b1;
                mem_idx    = pos_reg;
                wr_entry   = op_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_HEAD_RD;
            end
            ST_HEAD_RD:
            begin
                if (empty)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    ctl.rd_en  = 1'b1;
                    mem_idx    = '0;
                    state_next = ST_HEAD_CAP;
                end
            end
            ST_HEAD_CAP:
            begin
                head_next  = rd_entry;
                ctl.rd_en  = 1'b1;
                mem_idx    = count_dec;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next.status      = status_reg;
                    out_next.head_valid  = !empty;
                    out_next.head_key    = empty ? '0 : head_reg.key;
                    out_next.head_tag    = empty ? '0 : head_reg.tag;
                    out_next.tail_key    = empty ? '0 : rd_entry.key;
                    out_next.tail_tag    = empty ? '0 : rd_entry.tag;
                    out_next.entry_count = count_ext[COUNT_OUT_W-1:0];
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        op_reg     <= op_next;
        status_reg <= status_next;
        head_reg   <= head_next;
        out_reg    <= out_next;
    end

    siq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .idx      (mem_idx),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_put_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUT) |-> !full && (pos_reg <= count_reg))
        else $error("write of new entry without room");

    a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SH_WR) |-> (idx_reg > pos_reg) && (idx_reg <= count_reg))
        else $error("shift outside insertion range");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while one is in progress");

endmodule

[sim/siq_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// siq_checker
// Watches both channels of the sorted insert queue. Each accepted input item
// is applied to a shadow copy of the queue to form the expected result item,
// and each accepted result item is compared field by field with the oldest
// expected one. The failure count and the number of results still owed are
// handed to the testbench top.
// ============================================================================
module siq_checker #(
    parameter int DEPTH = siq_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  siq_pkg::in_t    in_data,
    input  logic            out_valid,
    input  logic            out_ready,
    input  siq_pkg::out_t   out_data,
    output int              fail_count,
    output int              results_owed
);
    import siq_pkg::*;

    entry_t shadow_slots [DEPTH];
    int     shadow_fill;
    out_t   awaited_reports [$];
    out_t   want;
    int     mismatches = 0;
    int     r;

    assign fail_count = mismatches;

    function automatic out_t apply_queue_op(in_t op);
        out_t rep;
        int   pos;
        int   i;
        bit   found;
        rep = '0;
        rep.status = STAT_OK;
        case (op.func)
            FUNC_INSERT, FUNC_APPEND:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    rep.status = STAT_FULL;
                end
                else
                begin
                    pos = shadow_fill;
                    if (op.func == FUNC_INSERT)
                    begin
                        // strictly greater than the head goes in front of it
                        if (shadow_fill == 0 || op.sort_key > shadow_slots[0].key)
                        begin
                            pos = 0;
                        end
                        else
                        begin
                            found = 1'b0;
                            for (i = 1; i < shadow_fill; i++)
                            begin
                                if (!found && shadow_slots[i].key <= op.sort_key)
                                begin
                                    pos = i;
                                    found = 1'b1;
                                end
                            end
                        end
                    end
                    for (i = shadow_fill; i > pos; i--)
                    begin
                        shadow_slots[i] = shadow_slots[i-1];
                    end
                    shadow_slots[pos] = '{key: op.sort_key, tag: op.record_tag};
                    shadow_fill++;
                end
            end
            FUNC_POP:
            begin
                if (shadow_fill == 0)
                begin
                    rep.status = STAT_EMPTY;
                end
                else
                begin
                    for (i = 1; i < shadow_fill; i++)
                    begin
                        shadow_slots[i-1] = shadow_slots[i];
                    end
                    shadow_fill--;
                end
            end
            default:
            begin
                shadow_fill = 0;
            end
        endcase
        if (shadow_fill > 0)
        begin
            rep.head_valid = 1'b1;
            rep.head_key   = shadow_slots[0].key;
            rep.head_tag   = shadow_slots[0].tag;
            rep.tail_key   = shadow_slots[shadow_fill-1].key;
            rep.tail_tag   = shadow_slots[shadow_fill-1].tag;
        end
        rep.entry_count = COUNT_OUT_W'(shadow_fill);
        return rep;
    endfunction

    task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %0h, got %0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_fill = 0;
            for (r = 0; r < DEPTH; r++)
            begin
                shadow_slots[r] = '0;
            end
            awaited_reports.delete();
            results_owed <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                awaited_reports.insert(awaited_reports.size(), apply_queue_op(in_data));
            end
            if (out_valid && out_ready)
            begin
                if (awaited_reports.size() == 0)
                begin
                    $error("result item arrived with none expected");
                    mismatches++;
                end
                else
                begin
                    want = awaited_reports[0];
                    awaited_reports.delete(0);
                    compare_field("status", 32'(want.status), 32'(out_data.status));
                    compare_field("head_valid", 32'(want.head_valid),
                                  32'(out_data.head_valid));
                    compare_field("head_key", want.head_key, out_data.head_key);
                    compare_field("head_tag", 32'(want.head_tag), 32'(out_data.head_tag));
                    compare_field("tail_key", want.tail_key, out_data.tail_key);
                    compare_field("tail_tag", 32'(want.tail_tag), 32'(out_data.tail_tag));
                    compare_field("entry_count", 32'(want.entry_count),
                                  32'(out_data.entry_count));
                end
            end
            results_owed <= awaited_reports.size();
        end
    end

endmodule

[sim/tb_sorted_insert_queue.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_sorted_insert_queue
// Drives the sorted insert queue with a directed opening (empty queue cases,
// ordering ties, pops down to empty, clear) and then phases of
// random operations biased to fill or drain the queue. Both channels idle at
// random; the receiver once holds off for a long stretch so the block stalls
// its input. The checker beside the block predicts and compares.
// ============================================================================
module tb_sorted_insert_queue;
    import siq_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;

    typedef enum { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    in_t  in_data   = '0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    out_t out_data;

    int   fail_count;
    int   results_owed;
    bit   long_hold = 1'b0;
    bit   steady    = 1'b0;
    int   sent      = 0;

    sorted_insert_queue #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    siq_checker #(.DEPTH(DEPTH)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 60)
            return 0;
        else if (p < 90)
            return $urandom_range(1, 3);
        else if (p < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        int p;
        p = $urandom_range(0, 9);
        case (p)
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5: return KEY_W'($urandom_range(0, 7));
            6:       return KEY_W'($urandom_range(32'hFFFF_FFFF, 32'hFFFF_FFFC));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    function automatic func_t pick_func(mix_t mix);
        int p;
        p = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
                if (p < 55) return FUNC_INSERT;
                else if (p < 85) return FUNC_APPEND;
                else if (p < 97) return FUNC_POP;
                else return FUNC_CLEAR;
            MIX_DRAIN:
                if (p < 15) return FUNC_INSERT;
                else if (p < 27) return FUNC_APPEND;
                else if (p < 97) return FUNC_POP;
                else return FUNC_CLEAR;
            default:
                if (p < 35) return FUNC_INSERT;
                else if (p < 55) return FUNC_APPEND;
                else if (p < 97) return FUNC_POP;
                else return FUNC_CLEAR;
        endcase
    endfunction

    task automatic send_item(func_t f, logic [KEY_W-1:0] k, logic [TAG_W-1:0] t);
        int gap;
        in_valid <= 1'b1;
        in_data  <= '{func: f, sort_key: k, record_tag: t};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // receiver: random ready with one long hold-off on request
    initial
    begin
        int run;
        int gap;
        bit hold_taken;
        hold_taken = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                run = $urandom_range(1, 16);
                out_ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = idle_len();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        mix_t mix;
        int   len;
        int   p;
        bit   held_once;
        held_once = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue cases
        send_item(FUNC_POP, '0, '0);
        send_item(FUNC_CLEAR, '1, '1);
        // ordering: front, tie with head, tie at later position, between
        send_item(FUNC_INSERT, '0, 16'h0000);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF, 16'h0001);
        send_item(FUNC_INSERT, '0, 16'h0002);
        send_item(FUNC_INSERT, 32'd7, 16'h0003);
        send_item(FUNC_APPEND, 32'd5, 16'h0004);
        send_item(FUNC_INSERT, 32'd5, 16'h0005);
        // pop down to empty, then once more
        repeat (8) send_item(FUNC_POP, 32'h1234_5678, 16'hA5A5);
        send_item(FUNC_APPEND, 32'h8000_0000, 16'h8000);
        send_item(FUNC_APPEND, 32'h0000_0001, 16'h0001);
        send_item(FUNC_CLEAR, '0, '0);
        wait_drained();

        while (sent < 900)
        begin
            p = $urandom_range(0, 2);
            mix = (p == 0) ? MIX_FILL : (p == 1) ? MIX_DRAIN : MIX_EVEN;
            len = $urandom_range(20, 60);
            steady = ($urandom_range(0, 5) == 0);
            if (!held_once && sent >= 400)
            begin
                long_hold <= 1'b1;
                held_once = 1'b1;
                steady = 1'b1;
                mix = MIX_FILL;
            end
            repeat (len) send_item(pick_func(mix), pick_key(), TAG_W'($urandom));
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        steady = 1'b0;
        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && results_owed == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
